FILE: hw/rtl/agls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agls_pkg
// Shared types and codes for the ASAP gate layer scheduler.
// ----------------------------------------------------------------------------
package agls_pkg;

  localparam logic [1:0] CMD_ONE    = 2'd0;
  localparam logic [1:0] CMD_CZ     = 2'd1;
  localparam logic [1:0] CMD_GLOBAL = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_PLACED   = 2'd0;
  localparam logic [1:0] ST_NO_LAYER = 2'd1;
  localparam logic [1:0] ST_BAD_QUB  = 2'd2;

  localparam logic REG_NUM_QUBITS = 1'b0;
  localparam logic REG_LAYER_CAP  = 1'b1;

  localparam int CFG_W = 13;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] qubit_a;
    logic [5:0] qubit_b;
  } in_t;

  typedef struct packed {
    logic [9:0]  layer;
    logic [5:0]  low_qubit;
    logic [5:0]  high_qubit;
    logic [10:0] layers_open;
    logic [1:0]  status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd;
    logic eval;
    logic fill_rd;
    logic step;
    logic commit;
    logic wr_b;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_scan;
    logic scan_more;
    logic fill_full;
    logic no_room;
  } sts_t;

endpackage

FILE: hw/rtl/agls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agls_ctrl
// Sequencer that walks one request through read, evaluate, scan and commit.
// ----------------------------------------------------------------------------
module agls_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output agls_pkg::ctl_t ctl,
  input  agls_pkg::sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_CHK    = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_WRB    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ctl.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        ctl.eval = 1'b1;
        if (sts.go_scan) begin
          state_nxt = S_SCAN;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_more) begin
          ctl.fill_rd = 1'b1;
          state_nxt   = S_CHK;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_CHK: begin
        if (sts.fill_full) begin
          ctl.step  = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        if (sts.no_room) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WRB;
        end
      end
      S_WRB: begin
        ctl.wr_b  = 1'b1;
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

FILE: hw/rtl/agls_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agls_dp
// Datapath: per-qubit layer memory, per-layer fill memory and result register.
// ----------------------------------------------------------------------------
module agls_dp #(
  parameter int MAX_QUBITS = 64,
  parameter int MAX_LAYERS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [agls_pkg::CFG_W-1:0]    cfg_wdata,
  input  agls_pkg::in_t                 in_req,
  input  agls_pkg::ctl_t                ctl,
  output agls_pkg::sts_t                sts,
  output agls_pkg::out_t                out_res
);

  localparam int QW = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
  localparam int LW = $clog2(MAX_LAYERS + 1);
  localparam int FW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam logic [LW-1:0] MAXL = LW'(MAX_LAYERS);

  logic [6:0]              nq_cfg_r;
  logic [12:0]             cap_cfg_r;
  agls_pkg::in_t           req_r;
  logic [MAX_QUBITS-1:0]   vld_r;
  logic [LW-1:0]           base_r;
  logic [LW-1:0]           nfl_mem [MAX_QUBITS];
  logic [LW-1:0]           rda_r, rdb_r;
  logic [LW-1:0]           max_r, open_r, layer_r;
  logic [12:0]             fill_mem [MAX_LAYERS];
  logic [12:0]             fill_q;
  agls_pkg::out_t          out_r;
  agls_pkg::out_t          eval_res;

  logic [QW-1:0] qa_i, qb_i;
  logic [31:0]   nq32;
  logic [5:0]    hi_glob, lo_cz, hi_cz;
  logic          qa_bad, qb_bad;
  logic [LW-1:0] cz_max, place;
  logic [12:0]   cap_eff;
  logic          new_layer;

  assign qa_i    = QW'(req_r.qubit_a);
  assign qb_i    = QW'(req_r.qubit_b);
  assign nq32    = (32'(nq_cfg_r) < 32'(MAX_QUBITS)) ? 32'(nq_cfg_r) : 32'(MAX_QUBITS);
  assign hi_glob = (nq32 == 32'd0) ? 6'd0 : 6'(nq32 - 32'd1);
  assign qa_bad  = (32'(req_r.qubit_a) >= nq32);
  assign qb_bad  = (32'(req_r.qubit_b) >= nq32);
  assign lo_cz   = (req_r.qubit_a < req_r.qubit_b) ? req_r.qubit_a : req_r.qubit_b;
  assign hi_cz   = (req_r.qubit_a < req_r.qubit_b) ? req_r.qubit_b : req_r.qubit_a;
  assign cz_max  = (rda_r > rdb_r) ? rda_r : rdb_r;
  assign cap_eff = (cap_cfg_r == 13'd0) ? 13'd1 : cap_cfg_r;
  assign new_layer = (layer_r >= open_r);
  assign place   = new_layer ? open_r : layer_r;

  assign sts.go_scan   = (req_r.cmd == agls_pkg::CMD_CZ) && !qa_bad && !qb_bad;
  assign sts.scan_more = (layer_r < open_r);
  assign sts.fill_full = (fill_q >= cap_eff);
  assign sts.no_room   = (layer_r >= MAXL);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nq_cfg_r  <= 7'd64;
      cap_cfg_r <= 13'd1;
      vld_r     <= '0;
      base_r    <= '0;
      max_r     <= '0;
      open_r    <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == agls_pkg::REG_NUM_QUBITS) begin
          nq_cfg_r <= cfg_wdata[6:0];
        end else begin
          cap_cfg_r <= cfg_wdata;
        end
      end
      if (ctl.eval) begin
        if (req_r.cmd == agls_pkg::CMD_CLEAR) begin
          vld_r  <= '0;
          base_r <= '0;
          max_r  <= '0;
          open_r <= '0;
        end else if (req_r.cmd == agls_pkg::CMD_GLOBAL && max_r < MAXL) begin
          vld_r  <= '0;
          base_r <= max_r;
        end
      end
      if (ctl.commit && !sts.no_room) begin
        vld_r[qa_i] <= 1'b1;
        if (new_layer) begin
          open_r <= open_r + 1'b1;
        end
        if (place + 1'b1 > max_r) begin
          max_r <= place + 1'b1;
        end
      end
      if (ctl.wr_b) begin
        vld_r[qb_i] <= 1'b1;
      end
    end
  end

  // Per-qubit next free layer memory; unwritten entries read as the base.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rda_r <= vld_r[qa_i] ? nfl_mem[qa_i] : base_r;
      rdb_r <= vld_r[qb_i] ? nfl_mem[qb_i] : base_r;
    end
    if (ctl.commit && !sts.no_room) begin
      nfl_mem[qa_i] <= place + 1'b1;
    end else if (ctl.wr_b) begin
      nfl_mem[qb_i] <= layer_r + 1'b1;
    end
  end

  // Per-layer fill memory.
  always_ff @(posedge clk) begin
    if (ctl.fill_rd) begin
      fill_q <= fill_mem[layer_r[FW-1:0]];
    end
    if (ctl.commit && !sts.no_room) begin
      fill_mem[place[FW-1:0]] <= new_layer ? 13'd1 : fill_q + 13'd1;
    end
  end

  // Result of the evaluate step for every command.
  always_comb begin
    eval_res             = '0;
    eval_res.layers_open = 11'(open_r);
    eval_res.status      = agls_pkg::ST_PLACED;
    unique case (req_r.cmd)
      agls_pkg::CMD_CLEAR: begin
        eval_res.layers_open = '0;
      end
      agls_pkg::CMD_GLOBAL: begin
        eval_res.high_qubit = hi_glob;
        if (max_r >= MAXL) begin
          eval_res.status = agls_pkg::ST_NO_LAYER;
        end else begin
          eval_res.layer = 10'(max_r);
        end
      end
      agls_pkg::CMD_ONE: begin
        eval_res.low_qubit  = req_r.qubit_a;
        eval_res.high_qubit = req_r.qubit_a;
        if (qa_bad) begin
          eval_res.status = agls_pkg::ST_BAD_QUB;
        end else if (rda_r >= MAXL) begin
          eval_res.status = agls_pkg::ST_NO_LAYER;
        end else begin
          eval_res.layer = 10'(rda_r);
        end
      end
      agls_pkg::CMD_CZ: begin
        eval_res.low_qubit  = lo_cz;
        eval_res.high_qubit = hi_cz;
        if (qa_bad || qb_bad) begin
          eval_res.status = agls_pkg::ST_BAD_QUB;
        end
      end
      default: begin
        eval_res.low_qubit = '0;
      end
    endcase
  end

  // Request capture, layer search register and result register.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= in_req;
    end
    if (ctl.step) begin
      layer_r <= layer_r + 1'b1;
    end
    if (ctl.commit && !sts.no_room) begin
      layer_r <= place;
    end
    if (ctl.eval) begin
      out_r   <= eval_res;
      layer_r <= cz_max;
    end
    if (ctl.commit) begin
      if (sts.no_room) begin
        out_r.layer       <= '0;
        out_r.status      <= agls_pkg::ST_NO_LAYER;
        out_r.layers_open <= 11'(open_r);
      end else begin
        out_r.layer       <= 10'(place);
        out_r.status      <= agls_pkg::ST_PLACED;
        out_r.layers_open <= new_layer ? 11'(open_r + 1'b1) : 11'(open_r);
      end
    end
  end

  assign out_res = out_r;

endmodule

FILE: hw/rtl/asap_gate_layer_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asap_gate_layer_scheduler
// Places gates in the earliest layer, with a cap on two-qubit gates per layer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown on out_res for a single cycle while out_valid is high. The
// receiver cannot stall, so it must capture the result in that cycle. Clear,
// one-qubit and global requests, and CZ requests with an out-of-range qubit,
// give their result after the read and evaluate steps. A CZ request scans
// from the later of its qubits' next free layers, reads each open layer's
// fill count, skips full layers, and commits to the first open layer with
// room or else a new layer, then writes the second qubit. A CZ request that
// finds no layer left skips the second write. The search reads layer fill
// counts one at a time from a single-port memory and the two qubit updates
// share one write port. busy falls in the cycle the result is shown, so a
// new request may be taken then. There is no clearing pass after reset:
// per-qubit layers are tracked with valid bits and a base value, and layer
// fill counts are only read for layers that were opened. Configuration is
// to be written by the user only while idle; the block has no check for it.
module asap_gate_layer_scheduler #(
  parameter int MAX_QUBITS = 64,
  parameter int MAX_LAYERS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  agls_pkg::in_t              in_req,
  output logic                       out_valid,
  output agls_pkg::out_t             out_res,
  input  logic                       cfg_we,
  input  logic                       cfg_idx,
  input  logic [agls_pkg::CFG_W-1:0] cfg_wdata
);

  agls_pkg::ctl_t ctl;
  agls_pkg::sts_t sts;

  // The controller sequences each request; it only sees status flags.
  agls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl),
    .sts       (sts)
  );

  // The datapath owns the memories, configuration and the result register.
  agls_dp #(
    .MAX_QUBITS (MAX_QUBITS),
    .MAX_LAYERS (MAX_LAYERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .ctl       (ctl),
    .sts       (sts),
    .out_res   (out_res)
  );

endmodule
